[rtl/tcpfe_pkg.sv]
// ----------------------------------------------------------------------------
// tcpfe_pkg
// Types and constants shared by the peak feature extractor modules.
// ----------------------------------------------------------------------------
package tcpfe_pkg;

    localparam int IDX_W  = 7;
    localparam int AMP_W  = 16;
    localparam int CH_W   = 2;
    localparam int NUM_CH = 3;

    localparam logic [CH_W-1:0] CH_FIRST = 2'd0;
    localparam logic [CH_W-1:0] CH_MID   = 2'd1;
    localparam logic [CH_W-1:0] CH_LAST  = 2'd2;

    typedef struct packed {
        logic [AMP_W-1:0] sample_ch0;
        logic [AMP_W-1:0] sample_ch1;
        logic [AMP_W-1:0] sample_ch2;
        logic             last_sample;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [IDX_W-1:0] entry_index;
        logic [IDX_W-1:0] top_index;
        logic [IDX_W-1:0] exit_index;
        logic [AMP_W-1:0] top_amplitude;
        logic             final_result;
    } out_t;

    // features of one channel
    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic [IDX_W-1:0] top_index;
        logic [IDX_W-1:0] exit_index;
        logic [AMP_W-1:0] top_amplitude;
    } feat_t;

    // snapshot of one finished window, one entry per channel
    typedef feat_t [NUM_CH-1:0] win_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[rtl/tcpfe_front.sv]
// ----------------------------------------------------------------------------
// tcpfe_front
// Per-channel peak tracking; pushes a window snapshot on the last sample.
// ----------------------------------------------------------------------------
module tcpfe_front #(
    parameter int WINDOW_DEPTH = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [tcpfe_pkg::AMP_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tcpfe_pkg::in_t              s_data,
    input  tcpfe_pkg::q_status_t        q_status,
    output logic                        push,
    output tcpfe_pkg::win_t             push_data
);
    import tcpfe_pkg::*;

    localparam int IdxLimitInt = (WINDOW_DEPTH - 1 > (1 << IDX_W) - 1) ?
                                 (1 << IDX_W) - 1 : WINDOW_DEPTH - 1;
    localparam logic [IDX_W-1:0] IdxLimit = IDX_W'(IdxLimitInt);

    logic [AMP_W-1:0]  threshold_reg;
    logic [NUM_CH-1:0] in_peak_reg, in_peak_next, in_peak_upd;
    win_t              feat_reg, feat_next, feat_upd;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [AMP_W-1:0]  samp [NUM_CH];
    logic              take;

    assign s_ready = !q_status.full;
    assign take    = s_valid && s_ready;

    assign samp[0] = s_data.sample_ch0;
    assign samp[1] = s_data.sample_ch1;
    assign samp[2] = s_data.sample_ch2;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            feat_upd[c]    = feat_reg[c];
            in_peak_upd[c] = in_peak_reg[c];
            if (samp[c] >= threshold_reg) begin
                if (!in_peak_reg[c]) begin
                    feat_upd[c].entry_index   = index_reg;
                    feat_upd[c].top_index     = index_reg;
                    feat_upd[c].top_amplitude = samp[c];
                    in_peak_upd[c]            = 1'b1;
                end else if (feat_reg[c].top_amplitude < samp[c]) begin
                    feat_upd[c].top_index     = index_reg;
                    feat_upd[c].top_amplitude = samp[c];
                end
            end else if (in_peak_reg[c]) begin
                feat_upd[c].exit_index = index_reg;
                in_peak_upd[c]         = 1'b0;
            end
        end
    end

    always_comb begin
        feat_next    = feat_reg;
        in_peak_next = in_peak_reg;
        index_next   = index_reg;
        if (take) begin
            if (s_data.last_sample) begin
                feat_next    = '0;
                in_peak_next = '0;
                index_next   = '0;
            end else begin
                feat_next    = feat_upd;
                in_peak_next = in_peak_upd;
                if (index_reg < IdxLimit) begin
                    index_next = index_reg + IDX_W'(1);
                end
            end
        end
    end

    assign push      = take && s_data.last_sample;
    assign push_data = feat_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            in_peak_reg   <= '0;
            feat_reg      <= '0;
            index_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                threshold_reg <= cfg_data;
            end
            in_peak_reg <= in_peak_next;
            feat_reg    <= feat_next;
            index_reg   <= index_next;
        end
    end

endmodule

[rtl/tcpfe_queue.sv]
// ----------------------------------------------------------------------------
// tcpfe_queue
// Two-entry queue of finished window snapshots between front and back.
// ----------------------------------------------------------------------------
module tcpfe_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tcpfe_pkg::win_t      push_data,
    input  logic                 pop,
    output tcpfe_pkg::win_t      head,
    output tcpfe_pkg::q_status_t q_status
);
    import tcpfe_pkg::*;

    win_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/tcpfe_back.sv]
// ----------------------------------------------------------------------------
// tcpfe_back
// Serializes each window snapshot into three results through an output register.
// ----------------------------------------------------------------------------
module tcpfe_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcpfe_pkg::win_t      head,
    input  tcpfe_pkg::q_status_t q_status,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tcpfe_pkg::out_t      m_data
);
    import tcpfe_pkg::*;

    logic            m_valid_reg, m_valid_next;
    out_t            m_data_reg, m_data_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            load_ok, load;
    feat_t           sel;

    assign load_ok = !m_valid_reg || m_ready;
    assign load    = load_ok && !q_status.empty;
    // head leaves the queue once its last channel is loaded
    assign pop     = load && (ch_reg == CH_LAST);

    always_comb begin
        case (ch_reg)
            CH_FIRST: sel = head[0];
            CH_MID:   sel = head[1];
            default:  sel = head[2];
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ch_next      = ch_reg;
        if (load) begin
            m_valid_next              = 1'b1;
            m_data_next.channel       = ch_reg;
            m_data_next.entry_index   = sel.entry_index;
            m_data_next.top_index     = sel.top_index;
            m_data_next.exit_index    = sel.exit_index;
            m_data_next.top_amplitude = sel.top_amplitude;
            m_data_next.final_result  = (ch_reg == CH_LAST);
            ch_next                   = (ch_reg == CH_LAST) ? CH_FIRST :
                                        ch_reg + CH_W'(1);
        end else if (load_ok) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ch_reg      <= CH_FIRST;
        end else begin
            m_valid_reg <= m_valid_next;
            ch_reg      <= ch_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/three_channel_peak_feature_extractor.sv]
// ----------------------------------------------------------------------------
// three_channel_peak_feature_extractor
// Threshold peak detection over a window of three-channel samples.
// ----------------------------------------------------------------------------
// Takes one sample triple per clock cycle while the snapshot queue has room.
// Channel state updates in the cycle a sample is accepted; the last sample of
// a window puts a snapshot of all three channels into a two-entry queue and
// clears the state, so the next window can start in the following cycle. The
// output side sends three results per window, one per cycle while m_ready is
// high (channel 0, 1, 2, final_result on channel 2), from a single output
// register. With windows of three or more samples and m_ready held high, the
// input runs at one sample per cycle. The sample index saturates at
// min(WINDOW_DEPTH - 1, 127). The threshold port is always ready and takes
// effect on the next sample.
module three_channel_peak_feature_extractor #(
    parameter int WINDOW_DEPTH = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcpfe_pkg::AMP_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tcpfe_pkg::in_t              s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tcpfe_pkg::out_t             m_data
);
    import tcpfe_pkg::*;

    q_status_t q_status;
    logic      push, pop;
    win_t      push_data, head;

    assign cfg_ready = 1'b1;

    tcpfe_front #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    tcpfe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    tcpfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef NO_ASSERTIONS
    // a window snapshot is never dropped at the queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("snapshot pushed into full queue");

    // final_result marks channel two and nothing else
    a_final_ch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.final_result == (m_data.channel == CH_LAST)))
        else $error("final_result on wrong channel");

    // channel zero is always followed at once by channel one of the same window
    a_ch_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.channel == CH_FIRST)
        |=> (m_valid && m_data.channel == CH_MID))
        else $error("result channel order broken");

    // the back side only pops a snapshot that is there
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule
